// File: src/dma4_pkg.sv
// ----------------------------------------------------------------------------
// dma4_pkg
// Shared types and constants of the four-channel dma controller.
// ----------------------------------------------------------------------------
package dma4_pkg;

	localparam int unsigned NCHAN = 4;
	localparam logic [1:0] START_DELAY_TICKS = 2'd2;
	localparam logic [2:0] NO_CHAN = 3'd4;
	localparam logic [27:0] ROM_BASE = 28'h8000000;
	localparam logic [27:0] EWRAM_BASE = 28'h2000000;
	localparam int unsigned QDEPTH = 2;

	// request kinds
	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_READ = 3'd1;
	localparam logic [2:0] REQ_TRIG = 3'd2;
	localparam logic [2:0] REQ_TICK = 3'd3;
	localparam logic [2:0] REQ_STEP = 3'd4;
	localparam logic [2:0] REQ_RET = 3'd5;

	// trigger occasions
	localparam logic [2:0] OCC_HBLANK = 3'd0;
	localparam logic [2:0] OCC_VBLANK = 3'd1;
	localparam logic [2:0] OCC_VIDEO = 3'd2;
	localparam logic [2:0] OCC_FIFO0 = 3'd3;
	localparam logic [2:0] OCC_FIFO1 = 3'd4;

	// response kinds
	localparam logic [1:0] RESP_NONE = 2'd0;
	localparam logic [1:0] RESP_REG = 2'd1;
	localparam logic [1:0] RESP_BRD = 2'd2;
	localparam logic [1:0] RESP_BWR = 2'd3;

	// register offsets
	localparam logic [3:0] OFF_LEN_LO = 4'd8;
	localparam logic [3:0] OFF_LEN_HI = 4'd9;
	localparam logic [3:0] OFF_CTL_LO = 4'd10;
	localparam logic [3:0] OFF_CTL_HI = 4'd11;

	// timing modes
	localparam logic [1:0] TIM_IMM = 2'd0;
	localparam logic [1:0] TIM_VBL = 2'd1;
	localparam logic [1:0] TIM_HBL = 2'd2;
	localparam logic [1:0] TIM_SPC = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [1:0] chan_sel;
		logic [3:0] reg_offset;
		logic [7:0] write_byte;
		logic [2:0] occasion;
		logic [31:0] bus_read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0] resp_kind;
		logic [7:0] reg_read_byte;
		logic [27:0] bus_addr;
		logic [31:0] bus_data;
		logic bus_word;
		logic bus_nonseq;
		logic irq_raise;
		logic [1:0] irq_channel;
		logic [2:0] active_channel;
	} out_item_t;

	// pure register reads are answered by the back end like everything else;
	// the front end only sorts requests and marks meaningless ones
	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] chan;
		logic [3:0] offset;
		logic [7:0] wbyte;
		logic [2:0] occ;
		logic [31:0] rdata;
		logic meaningful;
	} cmd_t;

	function automatic logic [27:0] src_lim(input logic [1:0] c);
		return (c == 2'd0) ? 28'h7FFFFFF : 28'hFFFFFFF;
	endfunction

	function automatic logic [27:0] dst_lim(input logic [1:0] c);
		return (c == 2'd3) ? 28'hFFFFFFF : 28'h7FFFFFF;
	endfunction

	function automatic logic [15:0] len_lim(input logic [1:0] c);
		return (c == 2'd3) ? 16'hFFFF : 16'h3FFF;
	endfunction

	// address step for a mode and size, as a 28-bit two's complement value
	function automatic logic [27:0] step_of(input logic [1:0] mode, input logic word,
			input logic is_dst);
		logic [27:0] mag;
		mag = word ? 28'd4 : 28'd2;
		case (mode)
			2'd0: return mag;
			2'd1: return (~mag) + 28'd1;
			2'd3: return is_dst ? mag : 28'd0;
			default: return 28'd0;
		endcase
	endfunction

	// lowest set channel, or none
	function automatic logic [2:0] pick(input logic [3:0] m);
		if (m[0]) return 3'd0;
		if (m[1]) return 3'd1;
		if (m[2]) return 3'd2;
		if (m[3]) return 3'd3;
		return NO_CHAN;
	endfunction

endpackage

// File: src/dma4_front.sv
// ----------------------------------------------------------------------------
// dma4_front
// Accepts requests, classifies them and pushes commands into a short queue.
// ----------------------------------------------------------------------------
module dma4_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  dma4_pkg::in_item_t in_data,
	output logic               cmd_valid,
	input  logic               cmd_pop,
	output dma4_pkg::cmd_t     cmd_head
);

	dma4_pkg::cmd_t q_mem_q [dma4_pkg::QDEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	dma4_pkg::cmd_t cmd_new;

	// classify the incoming request
	always_comb begin
		cmd_new.kind = in_data.req_type;
		cmd_new.chan = in_data.chan_sel;
		cmd_new.offset = in_data.reg_offset;
		cmd_new.wbyte = in_data.write_byte;
		cmd_new.occ = in_data.occasion;
		cmd_new.rdata = in_data.bus_read_data;
		cmd_new.meaningful = (in_data.req_type <= dma4_pkg::REQ_RET);
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd_head = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != 2'd0) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("bad count");

endmodule

// File: src/dma4_back.sv
// ----------------------------------------------------------------------------
// dma4_back
// Channel state, scheduling and transfers; one command per cycle into an
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module dma4_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  dma4_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output dma4_pkg::out_item_t out_data
);

	logic [27:0] src_reg_q [4];
	logic [27:0] dst_reg_q [4];
	logic [15:0] len_reg_q [4];
	logic [11:0] ctrl_reg_q [4];
	logic [27:0] work_src_q [4];
	logic [27:0] work_dst_q [4];
	logic [16:0] work_len_q [4];
	logic [31:0] latch_q [4];
	logic [3:0] fifo_q;
	logic [1:0] delay_q [4];
	logic [3:0] pend_q, run_q, hbl_q, vbl_q, vid_q;
	logic [2:0] act_q;
	logic rom_q, rw_q;
	logic [1:0] pch_q;
	logic pword_q;

	logic [27:0] n_src_reg [4];
	logic [27:0] n_dst_reg [4];
	logic [15:0] n_len_reg [4];
	logic [11:0] n_ctrl [4];
	logic [27:0] n_wsrc [4];
	logic [27:0] n_wdst [4];
	logic [16:0] n_wlen [4];
	logic [31:0] n_latch [4];
	logic [3:0] n_fifo;
	logic [1:0] n_delay [4];
	logic [3:0] n_pend, n_run, n_hbl, n_vbl, n_vid;
	logic [2:0] n_act;
	logic n_rom, n_rw;
	logic [1:0] n_pch;
	logic n_pword;
	dma4_pkg::out_item_t res;
	logic take;

	assign take = cmd_valid && (!out_valid || !out_stall);
	assign cmd_pop = take;

	// next-state logic for one command
	always_comb begin
		logic [1:0] c;
		logic [1:0] a;
		logic [4:0] sh;
		logic [11:0] ctl;
		logic [7:0] b;
		logic old_en;
		logic [27:0] al;
		logic [15:0] l;
		logic [16:0] rl;
		logic wd;
		logic do_wr;
		logic [1:0] wc;
		logic [31:0] wdata;
		logic [27:0] dst;
		logic [3:0] sm;
		logic dcmp;
		logic [1:0] dcc;
		logic [2:0] p;
		n_src_reg = src_reg_q; n_dst_reg = dst_reg_q; n_len_reg = len_reg_q;
		n_ctrl = ctrl_reg_q; n_wsrc = work_src_q; n_wdst = work_dst_q;
		n_wlen = work_len_q; n_latch = latch_q; n_fifo = fifo_q; n_delay = delay_q;
		n_pend = pend_q; n_run = run_q; n_hbl = hbl_q; n_vbl = vbl_q; n_vid = vid_q;
		n_act = act_q; n_rom = rom_q; n_rw = rw_q; n_pch = pch_q; n_pword = pword_q;
		res = '0;
		c = cmd.chan;
		a = act_q[1:0];
		sh = '0; ctl = '0; b = '0; old_en = 1'b0; al = '0; l = '0; rl = '0;
		wd = 1'b0; do_wr = 1'b0; wc = '0; wdata = '0; dst = '0; sm = '0;
		dcmp = 1'b0; dcc = '0; p = '0;
		case (cmd.kind)
			dma4_pkg::REQ_WRITE: begin
				if (cmd.offset < 4'd4) begin
					sh = {cmd.offset[1:0], 3'd0};
					n_src_reg[c] = (src_reg_q[c] & ~(28'hFF << sh))
						| ((28'(cmd.wbyte) << sh) & dma4_pkg::src_lim(c));
				end else if (cmd.offset < 4'd8) begin
					sh = {cmd.offset[1:0], 3'd0};
					n_dst_reg[c] = (dst_reg_q[c] & ~(28'hFF << sh))
						| ((28'(cmd.wbyte) << sh) & dma4_pkg::dst_lim(c));
				end else if (cmd.offset == dma4_pkg::OFF_LEN_LO) begin
					n_len_reg[c] = {len_reg_q[c][15:8], cmd.wbyte};
				end else if (cmd.offset == dma4_pkg::OFF_LEN_HI) begin
					n_len_reg[c] = {cmd.wbyte, len_reg_q[c][7:0]};
				end else if (cmd.offset == dma4_pkg::OFF_CTL_LO) begin
					n_ctrl[c] = {ctrl_reg_q[c][11:4], cmd.wbyte[7:5], 1'b0};
				end else if (cmd.offset == dma4_pkg::OFF_CTL_HI) begin
					old_en = ctrl_reg_q[c][11];
					b = (c == 2'd3) ? cmd.wbyte : (cmd.wbyte & 8'hF7);
					ctl = {b, ctrl_reg_q[c][3:0]};
					n_ctrl[c] = ctl;
					n_hbl[c] = 1'b0; n_vbl[c] = 1'b0; n_vid[c] = 1'b0;
					if (ctl[11]) begin
						if (!old_en) begin
							if (ctl[9:8] == dma4_pkg::TIM_SPC && (c == 2'd1 || c == 2'd2)) begin
								n_fifo[c] = 1'b1;
								n_ctrl[c][6] = 1'b1;
								n_wlen[c] = 17'd4;
								n_wsrc[c] = src_reg_q[c] & ~28'd3;
								n_wdst[c] = dst_reg_q[c] & ~28'd3;
							end else begin
								al = ctl[6] ? ~28'd3 : ~28'd1;
								n_fifo[c] = 1'b0;
								n_wsrc[c] = src_reg_q[c] & al;
								n_wdst[c] = dst_reg_q[c] & al;
								l = len_reg_q[c] & dma4_pkg::len_lim(c);
								n_wlen[c] = (l == 16'd0) ? (17'(dma4_pkg::len_lim(c)) + 17'd1)
									: 17'(l);
								if (ctl[9:8] == dma4_pkg::TIM_IMM) begin
									n_delay[c] = dma4_pkg::START_DELAY_TICKS;
									n_pend[c] = 1'b1;
								end else begin
									if (ctl[9:8] == dma4_pkg::TIM_VBL) n_vbl[c] = 1'b1;
									if (ctl[9:8] == dma4_pkg::TIM_HBL) n_hbl[c] = 1'b1;
									if (ctl[9:8] == dma4_pkg::TIM_SPC && c == 2'd3) n_vid[c] = 1'b1;
								end
							end
						end else if (!pend_q[c]) begin
							if (ctl[9:8] == dma4_pkg::TIM_VBL) n_vbl[c] = 1'b1;
							if (ctl[9:8] == dma4_pkg::TIM_HBL) n_hbl[c] = 1'b1;
							if (ctl[9:8] == dma4_pkg::TIM_SPC && c == 2'd3) n_vid[c] = 1'b1;
							if ({1'b0, c} == act_q) n_rom = 1'b0;
						end
					end else begin
						n_run[c] = 1'b0;
						n_pend[c] = 1'b0;
						n_delay[c] = 2'd0;
						if (rw_q && pch_q == c) n_rw = 1'b0;
						if ({1'b0, c} == act_q) begin
							n_rom = 1'b0;
							n_act = dma4_pkg::pick(n_run);
						end
					end
				end
			end
			dma4_pkg::REQ_READ: begin
				res.resp_kind = dma4_pkg::RESP_REG;
				if (cmd.offset == dma4_pkg::OFF_CTL_LO)
					res.reg_read_byte = {ctrl_reg_q[c][3:1], 5'd0};
				else if (cmd.offset == dma4_pkg::OFF_CTL_HI)
					res.reg_read_byte = ctrl_reg_q[c][11:4];
			end
			dma4_pkg::REQ_TRIG: begin
				sm = '0;
				case (cmd.occ)
					dma4_pkg::OCC_HBLANK: sm = hbl_q;
					dma4_pkg::OCC_VBLANK: sm = vbl_q;
					dma4_pkg::OCC_VIDEO: sm = vid_q;
					dma4_pkg::OCC_FIFO0:
						sm[1] = ctrl_reg_q[1][11] && ctrl_reg_q[1][9:8] == dma4_pkg::TIM_SPC;
					dma4_pkg::OCC_FIFO1:
						sm[2] = ctrl_reg_q[2][11] && ctrl_reg_q[2][9:8] == dma4_pkg::TIM_SPC;
					default: sm = '0;
				endcase
				for (int i = 0; i < 4; i++) begin
					if (sm[i]) begin
						n_delay[i] = dma4_pkg::START_DELAY_TICKS;
						n_pend[i] = 1'b1;
					end
				end
			end
			dma4_pkg::REQ_TICK: begin
				for (int i = 0; i < 4; i++) begin
					if (pend_q[i]) begin
						if (n_delay[i] != 2'd0) n_delay[i] = n_delay[i] - 2'd1;
						if (n_delay[i] == 2'd0) begin
							n_pend[i] = 1'b0;
							if (n_run == 4'd0 || 3'(i) < n_act) begin
								if (3'(i) != n_act) n_rom = 1'b0;
								n_act = 3'(i);
							end
							n_run[i] = 1'b1;
						end
					end
				end
			end
			dma4_pkg::REQ_STEP: begin
				if (act_q != dma4_pkg::NO_CHAN && !rw_q) begin
					wd = fifo_q[a] || ctrl_reg_q[a][6];
					if (work_len_q[a] == 17'd0) begin
						dcmp = 1'b1; dcc = a;
					end else if (work_src_q[a] >= dma4_pkg::EWRAM_BASE) begin
						res.resp_kind = dma4_pkg::RESP_BRD;
						res.bus_addr = work_src_q[a];
						res.bus_word = wd;
						if (!rom_q && work_src_q[a] >= dma4_pkg::ROM_BASE) begin
							res.bus_nonseq = 1'b1; n_rom = 1'b1;
						end
						n_rw = 1'b1; n_pch = a; n_pword = wd;
					end else begin
						do_wr = 1'b1; wc = a;
						wdata = wd ? latch_q[a] : (work_dst_q[a][1] ? {16'd0, latch_q[a][31:16]}
							: {16'd0, latch_q[a][15:0]});
					end
				end
			end
			dma4_pkg::REQ_RET: begin
				if (rw_q) begin
					n_rw = 1'b0;
					do_wr = 1'b1; wc = pch_q; wd = pword_q;
					if (pword_q) begin
						n_latch[pch_q] = cmd.rdata;
						wdata = cmd.rdata;
					end else begin
						n_latch[pch_q] = {cmd.rdata[15:0], cmd.rdata[15:0]};
						wdata = {16'd0, cmd.rdata[15:0]};
					end
				end
			end
			default: ;
		endcase
		// write phase
		if (do_wr) begin
			dst = work_dst_q[wc];
			res.resp_kind = dma4_pkg::RESP_BWR;
			res.bus_addr = dst;
			res.bus_data = wdata;
			res.bus_word = wd;
			if (!n_rom && dst >= dma4_pkg::ROM_BASE) begin
				res.bus_nonseq = 1'b1; n_rom = 1'b1;
			end
			n_wsrc[wc] = work_src_q[wc] + dma4_pkg::step_of(ctrl_reg_q[wc][4:3], wd, 1'b0);
			n_wdst[wc] = dst + (fifo_q[wc] ? 28'd0
				: dma4_pkg::step_of(ctrl_reg_q[wc][2:1], wd, 1'b1));
			n_wlen[wc] = work_len_q[wc] - 17'd1;
			if (n_wlen[wc] == 17'd0) begin
				dcmp = 1'b1; dcc = wc;
			end
		end
		// completion
		if (dcmp) begin
			ctl = ctrl_reg_q[dcc];
			n_run[dcc] = 1'b0;
			if (ctl[5] && ctl[9:8] != dma4_pkg::TIM_IMM) begin
				if (fifo_q[dcc]) begin
					n_wlen[dcc] = 17'd4;
				end else begin
					l = len_reg_q[dcc] & dma4_pkg::len_lim(dcc);
					rl = (l == 16'd0) ? (17'(dma4_pkg::len_lim(dcc)) + 17'd1) : 17'(l);
					n_wlen[dcc] = rl;
					if (ctl[2:1] == 2'd3)
						n_wdst[dcc] = dst_reg_q[dcc] & (ctl[6] ? ~28'd3 : ~28'd1);
				end
			end else begin
				n_hbl[dcc] = 1'b0; n_vbl[dcc] = 1'b0; n_vid[dcc] = 1'b0;
				n_ctrl[dcc][11] = 1'b0;
			end
			p = dma4_pkg::pick(n_run);
			n_act = p;
			n_rom = 1'b0;
			if (ctl[10]) begin
				res.irq_raise = 1'b1; res.irq_channel = dcc;
			end
		end
		res.active_channel = n_act;
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				src_reg_q[i] <= '0; dst_reg_q[i] <= '0; len_reg_q[i] <= '0;
				ctrl_reg_q[i] <= '0; work_src_q[i] <= '0; work_dst_q[i] <= '0;
				work_len_q[i] <= '0; latch_q[i] <= '0; delay_q[i] <= '0;
			end
			fifo_q <= '0; pend_q <= '0; run_q <= '0; hbl_q <= '0; vbl_q <= '0;
			vid_q <= '0; act_q <= dma4_pkg::NO_CHAN; rom_q <= 1'b0; rw_q <= 1'b0;
			pch_q <= '0; pword_q <= 1'b0;
		end else if (take && cmd.meaningful) begin
			src_reg_q <= n_src_reg; dst_reg_q <= n_dst_reg; len_reg_q <= n_len_reg;
			ctrl_reg_q <= n_ctrl; work_src_q <= n_wsrc; work_dst_q <= n_wdst;
			work_len_q <= n_wlen; latch_q <= n_latch; delay_q <= n_delay;
			fifo_q <= n_fifo; pend_q <= n_pend; run_q <= n_run; hbl_q <= n_hbl;
			vbl_q <= n_vbl; vid_q <= n_vid; act_q <= n_act; rom_q <= n_rom;
			rw_q <= n_rw; pch_q <= n_pch; pword_q <= n_pword;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// unknown kinds leave res empty apart from the current owner
	always_ff @(posedge clk) begin
		if (take) begin
			out_data <= res;
		end
	end

	a_act_run: assert property (@(posedge clk) disable iff (!arst_n)
		act_q != dma4_pkg::NO_CHAN |-> run_q[act_q[1:0]]) else $error("owner not runnable");
	a_act_none: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == 4'd0 |-> act_q == dma4_pkg::NO_CHAN) else $error("owner without runnable");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result lost");

endmodule

// File: src/four_channel_dma_controller_unit.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller_unit
// Four-channel dma controller: front end queues requests, back end runs them.
// ----------------------------------------------------------------------------
//  channel | signals                     | carries
//  in      | in_valid, in_stall, in_data | register, trigger, tick, step, read return
//  out     | out_valid, out_stall, out_data | one response per request
//
// One request per cycle sustained while the output is not stalled; a result
// passes through a queue slot, then the back end's output register.
// The back end's combinational channel update sets the rate.
// Reset is asynchronous; all channels come up disabled with no owner.
// A stalled output fills the two-entry queue, then stalls the input.
module four_channel_dma_controller_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dma4_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dma4_pkg::out_item_t out_data
);

	logic cmd_valid;
	logic cmd_pop;
	dma4_pkg::cmd_t cmd_head;

	dma4_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd_head(cmd_head)
	);

	dma4_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd_head),
		.cmd_pop(cmd_pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

// File: bench/dma4_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dma4_checker
// Watches both channels of the dma controller, keeps its own copy of the
// channel registers and latches, predicts one response per accepted request
// and compares every accepted response field by field, oldest first.
// ----------------------------------------------------------------------------
module dma4_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  dma4_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  dma4_pkg::out_item_t out_data,
	output int                  errors,
	output int                  outstanding,
	output int                  n_checked,
	output int                  n_writes,
	output int                  n_irqs
);

	// channel registers and working latches
	logic [27:0] src_r [4];
	logic [27:0] dst_r [4];
	logic [15:0] len_r [4];
	logic [11:0] ctl_r [4];
	logic [27:0] wsrc [4];
	logic [27:0] wdst [4];
	logic [16:0] wlen [4];
	logic [31:0] latch [4];
	logic        fifo [4];
	logic [1:0]  dly [4];
	logic [3:0]  pend_start, run, hbl, vbl, vid;
	logic [2:0]  owner;
	logic        rom_t, rd_wait, rd_word;
	logic [1:0]  rd_chan;

	dma4_pkg::out_item_t expq [$];
	dma4_pkg::out_item_t exp_item;

	function automatic logic [1:0] tim(input logic [1:0] c);
		return ctl_r[c][9:8];
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < 4; i++) begin
			src_r[i] = '0; dst_r[i] = '0; len_r[i] = '0; ctl_r[i] = '0;
			wsrc[i] = '0; wdst[i] = '0; wlen[i] = '0; latch[i] = '0;
			fifo[i] = 1'b0; dly[i] = '0;
		end
		pend_start = '0; run = '0; hbl = '0; vbl = '0; vid = '0;
		owner = dma4_pkg::NO_CHAN;
		rom_t = 1'b0; rd_wait = 1'b0; rd_word = 1'b0; rd_chan = '0;
	endfunction

	function automatic void take_bus(input logic [2:0] c);
		if (c != owner)
			rom_t = 1'b0;
		owner = c;
	endfunction

	function automatic void arm_start(input logic [3:0] m);
		for (int i = 0; i < 4; i++) begin
			if (m[i]) begin
				dly[i] = dma4_pkg::START_DELAY_TICKS;
				pend_start[i] = 1'b1;
			end
		end
	endfunction

	function automatic void drop_events(input logic [1:0] c);
		hbl[c] = 1'b0; vbl[c] = 1'b0; vid[c] = 1'b0;
	endfunction

	function automatic void add_events(input logic [1:0] c);
		if (tim(c) == dma4_pkg::TIM_VBL)
			vbl[c] = 1'b1;
		else if (tim(c) == dma4_pkg::TIM_HBL)
			hbl[c] = 1'b1;
		else if (tim(c) == dma4_pkg::TIM_SPC && c == 2'd3)
			vid[c] = 1'b1;
	endfunction

	function automatic logic [16:0] reload_count(input logic [1:0] c);
		logic [15:0] lim;
		logic [15:0] l;
		lim = (c == 2'd3) ? 16'hFFFF : 16'h3FFF;
		l = len_r[c] & lim;
		return (l == 0) ? {1'b0, lim} + 17'd1 : {1'b0, l};
	endfunction

	function automatic void make_runnable(input logic [1:0] c);
		if (run == 0)
			take_bus({1'b0, c});
		else if ({1'b0, c} < owner)
			take_bus({1'b0, c});
		run[c] = 1'b1;
	endfunction

	function automatic logic [2:0] lowest(input logic [3:0] m);
		for (int i = 0; i < 4; i++)
			if (m[i])
				return i[2:0];
		return dma4_pkg::NO_CHAN;
	endfunction

	// control high byte written: enable edge loads latches, disable stops
	function automatic void control_update(input logic [1:0] c, input logic old_en);
		logic [27:0] al;
		drop_events(c);
		if (ctl_r[c][11]) begin
			if (!old_en) begin
				wsrc[c] = src_r[c];
				wdst[c] = dst_r[c];
				if (tim(c) == dma4_pkg::TIM_SPC && (c == 2'd1 || c == 2'd2)) begin
					fifo[c] = 1'b1;
					ctl_r[c][6] = 1'b1;
					wlen[c] = 17'd4;
					wsrc[c] = wsrc[c] & ~28'd3;
					wdst[c] = wdst[c] & ~28'd3;
				end else begin
					al = ctl_r[c][6] ? ~28'd3 : ~28'd1;
					fifo[c] = 1'b0;
					wsrc[c] = wsrc[c] & al;
					wdst[c] = wdst[c] & al;
					wlen[c] = reload_count(c);
					if (tim(c) == dma4_pkg::TIM_IMM)
						arm_start(4'b1 << c);
					else
						add_events(c);
				end
			end else if (!pend_start[c]) begin
				add_events(c);
				if ({1'b0, c} == owner)
					rom_t = 1'b0;
			end
		end else begin
			run[c] = 1'b0;
			pend_start[c] = 1'b0;
			dly[c] = '0;
			if (rd_wait && rd_chan == c)
				rd_wait = 1'b0;
			if ({1'b0, c} == owner) begin
				rom_t = 1'b0;
				owner = lowest(run);
			end
		end
	endfunction

	// channel done: reload for repeat, else disable; returns irq enable
	function automatic logic finish_chan(input logic [1:0] c);
		logic [11:0] ctl;
		ctl = ctl_r[c];
		run[c] = 1'b0;
		if (ctl[5] && tim(c) != dma4_pkg::TIM_IMM) begin
			if (fifo[c]) begin
				wlen[c] = 17'd4;
			end else begin
				wlen[c] = reload_count(c);
				if (ctl[2:1] == 2'd3)
					wdst[c] = dst_r[c] & (ctl[6] ? ~28'd3 : ~28'd1);
			end
		end else begin
			drop_events(c);
			ctl_r[c][11] = 1'b0;
		end
		owner = lowest(run);
		rom_t = 1'b0;
		return ctl[10];
	endfunction

	function automatic void bus_write(input logic [1:0] c, input logic [31:0] data,
			input logic word, inout dma4_pkg::out_item_t o);
		logic [27:0] mag, sm, dm;
		logic [27:0] d;
		d = wdst[c];
		mag = word ? 28'd4 : 28'd2;
		case (ctl_r[c][4:3])
			2'd0: sm = mag;
			2'd1: sm = -mag;
			default: sm = '0;
		endcase
		case (ctl_r[c][2:1])
			2'd1: dm = -mag;
			2'd2: dm = '0;
			default: dm = mag;
		endcase
		if (fifo[c])
			dm = '0;
		o.resp_kind = dma4_pkg::RESP_BWR;
		o.bus_addr = d;
		o.bus_data = data;
		o.bus_word = word;
		if (!rom_t && d >= dma4_pkg::ROM_BASE) begin
			o.bus_nonseq = 1'b1;
			rom_t = 1'b1;
		end
		wsrc[c] = wsrc[c] + sm;
		wdst[c] = d + dm;
		wlen[c] = wlen[c] - 17'd1;
		if (wlen[c] == 0 && finish_chan(c)) begin
			o.irq_raise = 1'b1;
			o.irq_channel = c;
		end
	endfunction

	function automatic dma4_pkg::out_item_t predict(input dma4_pkg::in_item_t r);
		dma4_pkg::out_item_t o;
		logic [1:0]  c, a;
		logic [31:0] tmp, lim, lt, d;
		logic [4:0]  sh;
		logic [7:0]  b;
		logic        old_en, word;
		o = '0;
		c = r.chan_sel;
		case (r.req_type)
			dma4_pkg::REQ_WRITE: begin
				if (r.reg_offset < 4'd4) begin
					sh = {r.reg_offset[1:0], 3'b000};
					lim = (c == 2'd0) ? 32'h07FFFFFF : 32'h0FFFFFFF;
					tmp = ({4'h0, src_r[c]} & ~(32'hFF << sh))
						| (({24'h0, r.write_byte} << sh) & lim);
					src_r[c] = tmp[27:0];
				end else if (r.reg_offset < 4'd8) begin
					sh = {r.reg_offset[1:0], 3'b000};
					lim = (c == 2'd3) ? 32'h0FFFFFFF : 32'h07FFFFFF;
					tmp = ({4'h0, dst_r[c]} & ~(32'hFF << sh))
						| (({24'h0, r.write_byte} << sh) & lim);
					dst_r[c] = tmp[27:0];
				end else if (r.reg_offset == dma4_pkg::OFF_LEN_LO) begin
					len_r[c][7:0] = r.write_byte;
				end else if (r.reg_offset == dma4_pkg::OFF_LEN_HI) begin
					len_r[c][15:8] = r.write_byte;
				end else if (r.reg_offset == dma4_pkg::OFF_CTL_LO) begin
					ctl_r[c][3:0] = {r.write_byte[7:5], 1'b0};
				end else if (r.reg_offset == dma4_pkg::OFF_CTL_HI) begin
					old_en = ctl_r[c][11];
					b = r.write_byte;
					if (c != 2'd3)
						b[3] = 1'b0;
					ctl_r[c][11:4] = b;
					control_update(c, old_en);
				end
			end
			dma4_pkg::REQ_READ: begin
				o.resp_kind = dma4_pkg::RESP_REG;
				if (r.reg_offset == dma4_pkg::OFF_CTL_LO)
					o.reg_read_byte = {ctl_r[c][3:1], 5'b0};
				else if (r.reg_offset == dma4_pkg::OFF_CTL_HI)
					o.reg_read_byte = ctl_r[c][11:4];
			end
			dma4_pkg::REQ_TRIG: begin
				case (r.occasion)
					dma4_pkg::OCC_HBLANK: arm_start(hbl);
					dma4_pkg::OCC_VBLANK: arm_start(vbl);
					dma4_pkg::OCC_VIDEO: arm_start(vid);
					dma4_pkg::OCC_FIFO0, dma4_pkg::OCC_FIFO1: begin
						a = (r.occasion == dma4_pkg::OCC_FIFO0) ? 2'd1 : 2'd2;
						if (ctl_r[a][11] && tim(a) == dma4_pkg::TIM_SPC)
							arm_start(4'b1 << a);
					end
					default: ;
				endcase
			end
			dma4_pkg::REQ_TICK: begin
				for (int i = 0; i < 4; i++) begin
					if (pend_start[i]) begin
						if (dly[i] > 0)
							dly[i] = dly[i] - 2'd1;
						if (dly[i] == 0) begin
							pend_start[i] = 1'b0;
							make_runnable(i[1:0]);
						end
					end
				end
			end
			dma4_pkg::REQ_STEP: begin
				if (owner < dma4_pkg::NO_CHAN && !rd_wait) begin
					a = owner[1:0];
					word = fifo[a] | ctl_r[a][6];
					if (wlen[a] == 0) begin
						if (finish_chan(a)) begin
							o.irq_raise = 1'b1;
							o.irq_channel = a;
						end
					end else if (wsrc[a] >= dma4_pkg::EWRAM_BASE) begin
						o.resp_kind = dma4_pkg::RESP_BRD;
						o.bus_addr = wsrc[a];
						o.bus_word = word;
						if (!rom_t && wsrc[a] >= dma4_pkg::ROM_BASE) begin
							o.bus_nonseq = 1'b1;
							rom_t = 1'b1;
						end
						rd_wait = 1'b1;
						rd_chan = a;
						rd_word = word;
					end else begin
						// source below work ram: the latched open-bus value is written
						lt = latch[a];
						d = word ? lt : (wdst[a][1] ? {16'h0, lt[31:16]} : {16'h0, lt[15:0]});
						bus_write(a, d, word, o);
					end
				end
			end
			dma4_pkg::REQ_RET: begin
				if (rd_wait) begin
					rd_wait = 1'b0;
					if (rd_word) begin
						latch[rd_chan] = r.bus_read_data;
						bus_write(rd_chan, r.bus_read_data, 1'b1, o);
					end else begin
						latch[rd_chan] = {2{r.bus_read_data[15:0]}};
						bus_write(rd_chan, {16'h0, r.bus_read_data[15:0]}, 1'b0, o);
					end
				end
			end
			default: ;
		endcase
		o.active_channel = owner;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// predict on every accepted request, compare on every accepted response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expq.delete();
			errors = 0;
			outstanding = 0;
			n_checked = 0;
			n_writes = 0;
			n_irqs = 0;
		end else begin
			if (in_valid && !in_stall)
				expq.push_back(predict(in_data));
			if (out_valid && !out_stall) begin
				if (expq.size() == 0) begin
					$error("response with nothing expected");
					errors++;
				end else begin
					exp_item = expq.pop_front();
					n_checked++;
					if (exp_item.resp_kind == dma4_pkg::RESP_BWR)
						n_writes++;
					if (exp_item.irq_raise)
						n_irqs++;
					check_field("resp_kind", 32'(exp_item.resp_kind),
						32'(out_data.resp_kind));
					check_field("reg_read_byte", 32'(exp_item.reg_read_byte),
						32'(out_data.reg_read_byte));
					check_field("bus_addr", 32'(exp_item.bus_addr), 32'(out_data.bus_addr));
					check_field("bus_data", exp_item.bus_data, out_data.bus_data);
					check_field("bus_word", 32'(exp_item.bus_word), 32'(out_data.bus_word));
					check_field("bus_nonseq", 32'(exp_item.bus_nonseq),
						32'(out_data.bus_nonseq));
					check_field("irq_raise", 32'(exp_item.irq_raise),
						32'(out_data.irq_raise));
					check_field("irq_channel", 32'(exp_item.irq_channel),
						32'(out_data.irq_channel));
					check_field("active_channel", 32'(exp_item.active_channel),
						32'(out_data.active_channel));
				end
			end
			outstanding = expq.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the four-channel dma controller: directed corner requests,
// then channel programming runs with ticks, triggers, steps and read returns
// mixed with random noise, under random gaps, stalls and a long output hold.
// ----------------------------------------------------------------------------
module tb;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	dma4_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	dma4_pkg::out_item_t out_data;

	int errors, outstanding, n_checked, n_writes, n_irqs;
	int n_sent;
	bit quiet;
	bit hold_long;

	four_channel_dma_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	dma4_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .outstanding(outstanding), .n_checked(n_checked),
		.n_writes(n_writes), .n_irqs(n_irqs)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// send one request; entered and left at a rising edge
	task automatic send(input logic [2:0] t, input logic [1:0] c, input logic [3:0] off,
			input logic [7:0] b, input logic [2:0] occ, input logic [31:0] rd);
		dma4_pkg::in_item_t it;
		int g;
		it.req_type = t;
		it.chan_sel = c;
		it.reg_offset = off;
		it.write_byte = b;
		it.occasion = occ;
		it.bus_read_data = rd;
		in_valid <= 1'b1;
		in_data <= it;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		n_sent++;
		g = quiet ? 0 : $urandom_range(0, 11);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic reg_wr(input logic [1:0] c, input logic [3:0] off, input logic [7:0] b);
		send(dma4_pkg::REQ_WRITE, c, off, b, dma4_pkg::OCC_HBLANK, $urandom);
	endtask

	task automatic program_chan(input logic [1:0] c, input logic [27:0] s,
			input logic [27:0] d, input logic [15:0] l, input logic [7:0] lo,
			input logic [7:0] hi);
		for (int i = 0; i < 4; i++)
			reg_wr(c, i[3:0], s[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			reg_wr(c, 4'(i + 4), d[8*i +: 8]);
		reg_wr(c, dma4_pkg::OFF_LEN_LO, l[7:0]);
		reg_wr(c, dma4_pkg::OFF_LEN_HI, l[15:8]);
		reg_wr(c, dma4_pkg::OFF_CTL_LO, lo);
		reg_wr(c, dma4_pkg::OFF_CTL_HI, hi);
	endtask

	function automatic logic [27:0] pick_addr();
		case ($urandom_range(0, 3))
			0: return 28'($urandom_range(0, 255));
			1: return dma4_pkg::EWRAM_BASE + 28'($urandom_range(0, 255));
			2: return dma4_pkg::ROM_BASE + 28'($urandom_range(0, 255));
			default: return 28'($urandom);
		endcase
	endfunction

	task automatic noise();
		send(3'($urandom_range(0, 7)), 2'($urandom), 4'($urandom), 8'($urandom),
			3'($urandom_range(0, 7)), $urandom);
	endtask

	// program a channel, start it and push its transfer through
	task automatic chan_run();
		logic [1:0] c;
		logic [15:0] l;
		logic [7:0] lo, hi;
		int n;
		c = 2'($urandom);
		l = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
		lo = 8'($urandom);
		hi = 8'($urandom);
		hi[7] = ($urandom_range(0, 7) != 0);
		if ($urandom_range(0, 3) != 0)
			reg_wr(c, dma4_pkg::OFF_CTL_HI, 8'h00);
		program_chan(c, pick_addr(), pick_addr(), l, lo, hi);
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				send(dma4_pkg::REQ_TRIG, c, 4'($urandom), 8'($urandom),
					3'($urandom_range(0, 4)), $urandom);
			send(dma4_pkg::REQ_TICK, c, 4'($urandom), 8'($urandom), 3'($urandom), $urandom);
		end
		n = 2 * ((l > 6) ? 6 : l) + $urandom_range(2, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 15))
				0: send(dma4_pkg::REQ_TICK, c, 4'($urandom), 8'($urandom), 3'($urandom),
					$urandom);
				1: send(dma4_pkg::REQ_TRIG, c, 4'($urandom), 8'($urandom),
					3'($urandom_range(0, 4)), $urandom);
				2: send(dma4_pkg::REQ_READ, c, 4'($urandom), 8'($urandom), 3'($urandom),
					$urandom);
				3: reg_wr(c, dma4_pkg::OFF_CTL_HI, 8'($urandom));
				default: begin
					send(dma4_pkg::REQ_STEP, c, 4'($urandom), 8'($urandom), 3'($urandom),
						$urandom);
					send(dma4_pkg::REQ_RET, c, 4'($urandom), 8'($urandom), 3'($urandom),
						$urandom);
				end
			endcase
		end
	endtask

	task automatic random_until(input int target);
		while (n_sent < target) begin
			if ($urandom_range(0, 4) == 0)
				noise();
			else
				chan_run();
		end
	endtask

	// output side: random stalls, one long hold when asked
	initial begin
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				n = 400;
				hold_long = 1'b0;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 11);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		n_sent = 0;
		quiet = 1'b0;
		hold_long = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: unused offsets, unknown kinds, idle step and return
		send(dma4_pkg::REQ_READ, 2'd0, dma4_pkg::OFF_CTL_LO, 8'h00, dma4_pkg::OCC_HBLANK,
			32'h0);
		send(dma4_pkg::REQ_READ, 2'd3, dma4_pkg::OFF_CTL_HI, 8'hFF, dma4_pkg::OCC_HBLANK,
			32'h0);
		send(dma4_pkg::REQ_READ, 2'd1, 4'd15, 8'h00, dma4_pkg::OCC_HBLANK, 32'h0);
		reg_wr(2'd2, 4'd13, 8'hFF);
		send(3'd6, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'h0);
		send(3'd7, 2'd3, 4'd15, 8'hFF, 3'd7, 32'hFFFFFFFF);
		send(dma4_pkg::REQ_TRIG, 2'd0, 4'd0, 8'h00, 3'd5, 32'h0);
		send(dma4_pkg::REQ_STEP, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'h0);
		send(dma4_pkg::REQ_RET, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'hFFFFFFFF);
		// channel 3, immediate, word, irq, from rom to the top of memory
		program_chan(2'd3, 28'hFFFFFFF, 28'hFFFFFFC, 16'h0001, 8'h00, 8'hC4);
		send(dma4_pkg::REQ_TICK, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'h0);
		send(dma4_pkg::REQ_TICK, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'h0);
		send(dma4_pkg::REQ_STEP, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'h0);
		send(dma4_pkg::REQ_RET, 2'd0, 4'd0, 8'h00, dma4_pkg::OCC_HBLANK, 32'hA5A55A5A);

		// sender holds off until every response is back
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);

		random_until(280);
		quiet = 1'b1;
		random_until(480);
		quiet = 1'b0;
		hold_long = 1'b1;
		random_until(750);

		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		$display("sent %0d requests, checked %0d responses", n_sent, n_checked);
		$display("bus writes %0d, interrupts %0d", n_writes, n_irqs);
		if (errors == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
src/dma4_pkg.sv
src/dma4_front.sv
src/dma4_back.sv
src/four_channel_dma_controller_unit.sv
bench/dma4_checker.sv
bench/tb.sv
